// ----- rtl/scipd_pkg.sv -----
`default_nettype none

package scipd_pkg;

  // Filter coefficients, Q0.16
  localparam logic signed [10:0] COEF_SAMPLE   = 11'sd1016;
  localparam logic signed [16:0] COEF_FEEDBACK = 17'sd63504;

  // Reset values
  localparam logic [14:0]        THRESHOLD_RESET = 15'd4915;   // 1.2 g in Q3.12
  localparam logic signed [31:0] ONE_G_Q28       = 32'sd268435456;

  localparam int unsigned THR_W = 15;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] level_t;
  typedef logic [THR_W-1:0]   thresh_t;
  typedef logic [31:0]        count_t;

endpackage : scipd_pkg

`default_nettype wire

// ----- rtl/scipd_in_if.sv -----
`default_nettype none

interface scipd_in_if
  import scipd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t accel_sample;
  logic    hold;

  modport source (output valid, output accel_sample, output hold, input ready);
  modport sink   (input valid, input accel_sample, input hold, output ready);
endinterface : scipd_in_if

`default_nettype wire

// ----- rtl/scipd_out_if.sv -----
`default_nettype none

interface scipd_out_if
  import scipd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  count_t  step_count;
  logic    step_seen;
  sample_t smoothed_level;
  logic    led_level;

  modport source (output valid, output step_count, output step_seen,
                  output smoothed_level, output led_level, input ready);
  modport sink   (input valid, input step_count, input step_seen,
                  input smoothed_level, input led_level, output ready);
endinterface : scipd_out_if

`default_nettype wire

// ----- rtl/step_counter_iir_peak_detect.sv -----
`default_nettype none

// A request passes the input register and then the result register on its way to the result.
// Throughput: one request per cycle unless the result side stalls; the filter/peak state
//   loop is combinational: a 32x17 multiply, one add with saturation and three compares.
// Reset (rst_n low, synchronous): filter and peak state, step total, heartbeat and both
//   valid flags clear; reference level goes to 1 g and the threshold to 1.2 g.
module step_counter_iir_peak_detect
  import scipd_pkg::*;
#(
  parameter int unsigned LED_TICKS = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  scipd_in_if.sink      in_chan,
  scipd_out_if.source   out_chan,
  input  wire           cfg_we,
  input  wire [THR_W-1:0] cfg_wdata
);

  localparam int unsigned LedW = (LED_TICKS > 2) ? $clog2(LED_TICKS) : 1;
  localparam logic [LedW-1:0] LedLast = LedW'(LED_TICKS - 1);

  // Input register
  logic    in_vld_r;
  sample_t in_sample_r;
  logic    in_hold_r;

  // Result register
  logic    out_vld_r;
  count_t  out_count_r;
  logic    out_seen_r;
  sample_t out_level_r;
  logic    out_led_r;

  // Block state
  sample_t          prev_sample_r;
  level_t           filter_level_r;
  level_t           ref_level_r;
  logic             was_rising_r;
  count_t           step_total_r;
  logic [LedW-1:0]  led_div_r;
  logic             led_r;
  thresh_t          thresh_r;

  // Next values
  sample_t          prev_sample_nxt;
  level_t           filter_level_nxt;
  level_t           ref_level_nxt;
  logic             was_rising_nxt;
  count_t           step_total_nxt;
  logic [LedW-1:0]  led_div_nxt;
  logic             led_nxt;
  logic             seen_nxt;

  // Handshake: the result register frees when the sink takes it, so the
  // input register can advance in the same cycle.
  logic out_load;
  assign out_load      = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || out_load;

  // Filter datapath
  logic signed [16:0] pair_sum;
  logic signed [27:0] ff_term;
  logic signed [48:0] fb_prod;
  logic signed [32:0] fb_term;
  logic signed [33:0] y_wide;
  level_t             y_sat;
  logic signed [33:0] y_cmp;
  logic signed [33:0] ref_cmp;
  logic signed [33:0] thr_cmp;

  always_comb begin
    // feed-forward: c1 * (x + x_prev), exact in Q3.28
    pair_sum = 17'(in_sample_r) + 17'(prev_sample_r);
    ff_term  = 28'(pair_sum) * 28'(COEF_SAMPLE);
    // feedback: c2 * y_prev, floor-shifted back to Q3.28
    fb_prod  = 49'(filter_level_r) * 49'(COEF_FEEDBACK);
    fb_term  = fb_prod[48:16];
    y_wide   = 34'(fb_term) + 34'(ff_term);
    // clamp to the signed 32-bit range
    if (y_wide > 34'sd2147483647) begin
      y_sat = 32'sh7fffffff;
    end else if (y_wide < -34'sd2147483648) begin
      y_sat = 32'sh80000000;
    end else begin
      y_sat = y_wide[31:0];
    end
    y_cmp   = 34'(y_sat);
    ref_cmp = 34'(ref_level_r);
    thr_cmp = $signed({3'b000, thresh_r, 16'h0000});
  end

  // State update for one accepted sample; a held sample changes nothing.
  always_comb begin
    prev_sample_nxt  = prev_sample_r;
    filter_level_nxt = filter_level_r;
    ref_level_nxt    = ref_level_r;
    was_rising_nxt   = was_rising_r;
    step_total_nxt   = step_total_r;
    led_div_nxt      = led_div_r;
    led_nxt          = led_r;
    seen_nxt         = 1'b0;
    if (in_vld_r && out_load && !in_hold_r) begin
      // peak: was rising, now falling, and above threshold
      if (was_rising_r && (y_cmp < ref_cmp) && (y_cmp > thr_cmp)) begin
        step_total_nxt = step_total_r + 32'd1;
        seen_nxt       = 1'b1;
      end
      prev_sample_nxt  = in_sample_r;
      filter_level_nxt = y_sat;
      was_rising_nxt   = y_cmp > ref_cmp;
      ref_level_nxt    = y_sat;
      // heartbeat divider: toggle on wrap
      if (led_div_r >= LedLast) begin
        led_div_nxt = '0;
        led_nxt     = !led_r;
      end else begin
        led_div_nxt = led_div_r + LedW'(1);
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      prev_sample_r  <= '0;
      filter_level_r <= '0;
      ref_level_r    <= ONE_G_Q28;
      was_rising_r   <= 1'b0;
      step_total_r   <= '0;
      led_div_r      <= '0;
      led_r          <= 1'b0;
      thresh_r       <= THRESHOLD_RESET;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      prev_sample_r  <= prev_sample_nxt;
      filter_level_r <= filter_level_nxt;
      ref_level_r    <= ref_level_nxt;
      was_rising_r   <= was_rising_nxt;
      step_total_r   <= step_total_nxt;
      led_div_r      <= led_div_nxt;
      led_r          <= led_nxt;
      // the user must write config only while idle; the block itself does not enforce it
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: capture the request, hold while stalled
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_sample_r <= in_chan.accel_sample;
      in_hold_r   <= in_chan.hold;
    end
    if (out_load) begin
      out_count_r <= step_total_nxt;
      out_seen_r  <= seen_nxt;
      out_level_r <= filter_level_nxt[31:16];   // floor to Q3.12
      out_led_r   <= led_nxt;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.step_count     = out_count_r;
  assign out_chan.step_seen      = out_seen_r;
  assign out_chan.smoothed_level = out_level_r;
  assign out_chan.led_level      = out_led_r;

endmodule : step_counter_iir_peak_detect

`default_nettype wire

// ----- test/tb_step_counter_iir_peak_detect.sv -----
`timescale 1ns / 100ps

module tb_step_counter_iir_peak_detect
  import scipd_pkg::*;
  ();

  localparam int unsigned LED_TICKS       = 16;
  localparam int unsigned IDLE_PCT        = 17;   // chance of a bubble per cycle, each side
  localparam int unsigned HOLD_OFF_CYCLES = 300;  // long result-side stall
  localparam int unsigned SETTLE_CYCLES   = 10;   // wait before the final summary

  // One result request as the block should present it.
  typedef struct {
    count_t  step_count;
    logic    step_seen;
    sample_t smoothed_level;
    logic    led_level;
  } step_report_t;

  // Pedometer predictor plus the queue of results still owed by the block.
  class step_tracker;
    sample_t      prev_sample;
    level_t       filt_level;
    level_t       peak_ref;
    bit           rising;
    count_t       total_steps;
    int unsigned  led_div;
    bit           led_on;
    thresh_t      threshold;
    step_report_t reports_due[$];
    int unsigned  failures;
    int unsigned  ticks;
    int unsigned  held_ticks;
    int unsigned  steps_predicted;
    int unsigned  reports_checked;

    function new();
      prev_sample     = '0;
      filt_level      = '0;
      peak_ref        = ONE_G_Q28;
      rising          = 1'b0;
      total_steps     = '0;
      led_div         = 0;
      led_on          = 1'b0;
      threshold       = THRESHOLD_RESET;
      failures        = 0;
      ticks           = 0;
      held_ticks      = 0;
      steps_predicted = 0;
      reports_checked = 0;
    endfunction

    function void set_threshold(thresh_t value);
      threshold = value;
    endfunction

    // Advance the predictor by one accepted tick and queue the result it owes.
    function void note_tick(sample_t accel, logic hold);
      longint       y;
      longint       peak_floor;
      bit           seen;
      step_report_t rpt;
      seen = 1'b0;
      ticks++;
      if (hold) begin
        held_ticks++;
      end else begin
        // c1*(x + x_prev) is exact; c2*y_prev drops 16 bits toward minus infinity
        y = longint'(COEF_SAMPLE) * (longint'(accel) + longint'(prev_sample))
            + ((longint'(filt_level) * longint'(COEF_FEEDBACK)) >>> 16);
        if (y > longint'(32'sh7FFF_FFFF)) y = longint'(32'sh7FFF_FFFF);
        if (y < -longint'(64'sh8000_0000)) y = -longint'(64'sh8000_0000);
        peak_floor = longint'(threshold) <<< 16;
        // count on the first fall after a rise, if the new level clears the threshold
        if (rising && (y < longint'(peak_ref)) && (y > peak_floor)) begin
          total_steps = total_steps + 1;
          seen = 1'b1;
          steps_predicted++;
        end
        prev_sample = accel;
        filt_level  = level_t'(y);
        rising      = (y > longint'(peak_ref));
        peak_ref    = level_t'(y);
        if (led_div >= LED_TICKS - 1) begin
          led_on  = ~led_on;
          led_div = 0;
        end else begin
          led_div++;
        end
      end
      rpt.step_count     = total_steps;
      rpt.step_seen      = seen;
      rpt.smoothed_level = sample_t'(filt_level >>> 16);
      rpt.led_level      = led_on;
      reports_due.push_back(rpt);
    endfunction

    function void check_report(count_t cnt, logic seen, sample_t lvl, logic led);
      step_report_t want;
      if (reports_due.size() == 0) begin
        $error("unexpected result: step_count %0d step_seen %0b smoothed_level %0d",
               cnt, seen, lvl);
        failures++;
        return;
      end
      want = reports_due.pop_front();
      reports_checked++;
      if (cnt !== want.step_count) begin
        $error("step_count: expected %0d, actual %0d", want.step_count, cnt);
        failures++;
      end
      if (seen !== want.step_seen) begin
        $error("step_seen: expected %0b, actual %0b", want.step_seen, seen);
        failures++;
      end
      if (lvl !== want.smoothed_level) begin
        $error("smoothed_level: expected %0d, actual %0d", want.smoothed_level, lvl);
        failures++;
      end
      if (led !== want.led_level) begin
        $error("led_level: expected %0b, actual %0b", want.led_level, led);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    cfg_we;
  thresh_t cfg_wdata;

  scipd_in_if  in_if ();
  scipd_out_if out_if ();

  step_tracker tracker = new();

  bit          no_idle;           // both sides run without bubbles while set
  bit          hold_off_request;  // ask the result side for one long stall
  int unsigned threshold_writes;

  step_counter_iir_peak_detect #(
    .LED_TICKS (LED_TICKS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond any correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Observe every handshake and register write at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        tracker.set_threshold(cfg_wdata);
        threshold_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        tracker.note_tick(in_if.accel_sample, in_if.hold);
      end
      if (out_if.valid && out_if.ready) begin
        tracker.check_report(out_if.step_count, out_if.step_seen,
                             out_if.smoothed_level, out_if.led_level);
      end
    end
  end

  // Result side: random bubbles, bubble-free stretches, and on request one long
  // stall counted here so the block backs up into its input.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one tick, after random bubbles; return once it is accepted.
  task automatic send_tick(input sample_t accel, input logic hold);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.accel_sample <= accel;
    in_if.hold         <= hold;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_reports();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Only called with the block empty.
  task automatic write_threshold(input thresh_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Gait-like square wave with jitter: the filter turns it into rounded peaks,
  // which is what the peak detector needs to see.
  task automatic run_walk(input int n, input int unsigned hold_pct);
    int hi;
    int lo;
    int left;
    int v;
    bit up;
    hi   = int'($urandom_range(32767, 3000));
    lo   = int'($urandom_range(16000, 0)) - 12000;
    up   = 1'b1;
    left = 0;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        up   = ~up;
        left = int'($urandom_range(40, 6));
      end
      left--;
      v = (up ? hi : lo) + int'($urandom_range(2000, 0)) - 1000;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_tick(sample_t'(v), ($urandom_range(99) < hold_pct));
    end
  endtask

  // Full-range samples with frequent holds: shakes every input bit.
  task automatic run_noise(input int n);
    for (int k = 0; k < n; k++) begin
      send_tick(sample_t'($urandom), ($urandom_range(9) == 0));
    end
  endtask

  task automatic run_level(input int n, input sample_t accel);
    for (int k = 0; k < n; k++) begin
      send_tick(accel, 1'b0);
    end
  endtask

  // Directed opening: full-scale swings, holds on extremes, small and odd values.
  sample_t dir_accel [20] = '{16'sd0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                              16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                              -16'sd32768, -16'sd32768, -16'sd1, 16'sd1, 16'sd0,
                              16'sd21845, -16'sd21846, -16'sd32768, -16'sd32768, 16'sd0};
  logic    dir_hold  [20] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                              1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.accel_sample = '0;
    in_if.hold         = 1'b0;
    out_if.ready       = 1'b0;
    no_idle            = 1'b0;
    hold_off_request   = 1'b0;
    threshold_writes   = 0;

    // Hold reset, then release it on a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks run at the reset threshold of 1.2 g.
    for (int i = 0; i < 20; i++) begin
      send_tick(dir_accel[i], dir_hold[i]);
    end
    drain_reports();

    // Zero threshold: any peak above zero counts. Run without bubbles on either side.
    write_threshold('0);
    no_idle = 1'b1;
    repeat (6) run_walk(50, 5);
    no_idle = 1'b0;
    drain_reports();

    // Top threshold: push the filter to both rails and hold it there.
    write_threshold(thresh_t'(15'h7FFF));
    run_level(60, 16'sh7FFF);
    run_level(100, -16'sh8000);
    run_walk(70, 5);
    run_walk(70, 5);
    drain_reports();

    // Random thresholds across the walking range, with backpressure episodes.
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        write_threshold(thresh_t'($urandom_range(32767)));
      end else begin
        write_threshold(thresh_t'($urandom_range(12000, 1500)));
      end
      // Stall the result side while ticks keep coming, so the input backs up.
      if (p == 1 || p == 4) hold_off_request = 1'b1;
      run_walk(50, 5);
      run_walk(50, 5);
      // Let everything drain mid-phase before the remaining walks.
      if (p == 3) drain_reports();
      run_walk(50, 5);
      run_walk(50, 5);
      run_noise(30);
      drain_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks (%0d held) across %0d threshold settings.",
             tracker.ticks, tracker.held_ticks, threshold_writes + 1);
    $display("%0d results checked, %0d of them counting a step.",
             tracker.reports_checked, tracker.steps_predicted);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/scipd_pkg.sv
rtl/scipd_in_if.sv
rtl/scipd_out_if.sv
rtl/step_counter_iir_peak_detect.sv
test/tb_step_counter_iir_peak_detect.sv
